/* hw/rtl/sfp_pkg.sv */
// Shared types and constants of the serial frame parser.
package sfp_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam int RAM_AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    typedef enum logic [3:0] {
        PH_HEAD1,
        PH_HEAD2,
        PH_ADDR,
        PH_LEN,
        PH_EVT,
        PH_PAY,
        PH_CSUM,
        PH_TAIL1,
        PH_TAIL2
    } t_phase;

    typedef enum logic [1:0] {
        OS_IDLE,
        OS_READ,
        OS_LOAD
    } t_ostate;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_HEAD     = 3'd1,
        ST_ADDRESS  = 3'd2,
        ST_CHECKSUM = 3'd3,
        ST_TAIL     = 3'd4,
        ST_TOO_LONG = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        CFG_HEAD_FIRST   = 3'd0,
        CFG_HEAD_SECOND  = 3'd1,
        CFG_NODE_ADDRESS = 3'd2,
        CFG_TAIL_FIRST   = 3'd3,
        CFG_TAIL_SECOND  = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic       valid;
        t_status    status;
        logic [7:0] event_code;
        logic [7:0] length;
        logic       replay;
    } t_result_req;

endpackage

/* hw/rtl/sfp_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module sfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/sfp_parser.sv */
// Frame parser: configuration registers, byte-wise frame state and payload store writes.
module sfp_parser (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    input  logic [2:0]                i_cfg_index,
    input  logic [7:0]                i_cfg_data,
    input  logic                      i_accept,
    input  logic [7:0]                i_rx_byte,
    output sfp_pkg::t_result_req      o_req,
    output logic                      o_wr_en,
    output logic [sfp_pkg::RAM_AW-1:0] o_wr_addr,
    output logic [7:0]                o_wr_data
);

    logic [7:0] r_head_first, r_head_second, r_node_address, r_tail_first, r_tail_second;

    sfp_pkg::t_phase           r_phase, n_phase;
    logic [7:0]                r_first_head, n_first_head;
    logic [7:0]                r_sum, n_sum;
    logic [7:0]                r_len, n_len;
    logic [7:0]                r_evt, n_evt;
    logic [sfp_pkg::CNT_W-1:0] r_taken, n_taken;
    logic [sfp_pkg::CNT_W-1:0] taken_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_first   <= 8'd0;
            r_head_second  <= 8'd0;
            r_node_address <= 8'd0;
            r_tail_first   <= 8'd0;
            r_tail_second  <= 8'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sfp_pkg::CFG_HEAD_FIRST:   r_head_first   <= i_cfg_data;
                sfp_pkg::CFG_HEAD_SECOND:  r_head_second  <= i_cfg_data;
                sfp_pkg::CFG_NODE_ADDRESS: r_node_address <= i_cfg_data;
                sfp_pkg::CFG_TAIL_FIRST:   r_tail_first   <= i_cfg_data;
                sfp_pkg::CFG_TAIL_SECOND:  r_tail_second  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= sfp_pkg::PH_HEAD1;
            r_first_head <= 8'd0;
            r_sum        <= 8'd0;
            r_len        <= 8'd0;
            r_evt        <= 8'd0;
            r_taken      <= '0;
        end else begin
            r_phase      <= n_phase;
            r_first_head <= n_first_head;
            r_sum        <= n_sum;
            r_len        <= n_len;
            r_evt        <= n_evt;
            r_taken      <= n_taken;
        end
    end

    assign taken_inc = r_taken + sfp_pkg::CNT_W'(1);

    always_comb begin
        n_phase      = r_phase;
        n_first_head = r_first_head;
        n_sum        = r_sum;
        n_len        = r_len;
        n_evt        = r_evt;
        n_taken      = r_taken;
        o_req        = '0;
        o_wr_en      = 1'b0;
        o_wr_addr    = r_taken[sfp_pkg::RAM_AW-1:0];
        o_wr_data    = i_rx_byte;
        if (i_accept) begin
            case (r_phase)
                sfp_pkg::PH_HEAD1: begin
                    n_first_head = i_rx_byte;
                    n_phase      = sfp_pkg::PH_HEAD2;
                end
                sfp_pkg::PH_HEAD2: begin
                    if (r_first_head != r_head_first || i_rx_byte != r_head_second) begin
                        o_req.valid  = 1'b1;
                        o_req.status = sfp_pkg::ST_HEAD;
                        n_phase      = sfp_pkg::PH_HEAD1;
                    end else begin
                        n_phase = sfp_pkg::PH_ADDR;
                    end
                end
                sfp_pkg::PH_ADDR: begin
                    if (i_rx_byte != r_node_address) begin
                        o_req.valid  = 1'b1;
                        o_req.status = sfp_pkg::ST_ADDRESS;
                        n_phase      = sfp_pkg::PH_HEAD1;
                    end else begin
                        n_phase = sfp_pkg::PH_LEN;
                    end
                end
                sfp_pkg::PH_LEN: begin
                    n_len   = i_rx_byte;
                    n_sum   = i_rx_byte;
                    n_taken = '0;
                    if (i_rx_byte > 8'(sfp_pkg::MAX_PAYLOAD)) begin
                        o_req.valid  = 1'b1;
                        o_req.status = sfp_pkg::ST_TOO_LONG;
                        o_req.length = i_rx_byte;
                        n_phase      = sfp_pkg::PH_HEAD1;
                    end else begin
                        n_phase = sfp_pkg::PH_EVT;
                    end
                end
                sfp_pkg::PH_EVT: begin
                    n_evt   = i_rx_byte;
                    n_sum   = r_sum + i_rx_byte;
                    n_phase = (r_len == 8'd0) ? sfp_pkg::PH_CSUM : sfp_pkg::PH_PAY;
                end
                sfp_pkg::PH_PAY: begin
                    o_wr_en = (r_taken < sfp_pkg::CNT_W'(sfp_pkg::MAX_PAYLOAD));
                    n_sum   = r_sum + i_rx_byte;
                    n_taken = taken_inc;
                    if (8'(taken_inc) >= r_len) begin
                        n_phase = sfp_pkg::PH_CSUM;
                    end
                end
                sfp_pkg::PH_CSUM: begin
                    if (i_rx_byte != r_sum) begin
                        o_req.valid      = 1'b1;
                        o_req.status     = sfp_pkg::ST_CHECKSUM;
                        o_req.event_code = r_evt;
                        o_req.length     = r_len;
                        n_phase          = sfp_pkg::PH_HEAD1;
                    end else begin
                        n_phase = sfp_pkg::PH_TAIL1;
                    end
                end
                sfp_pkg::PH_TAIL1: begin
                    if (i_rx_byte != r_tail_first) begin
                        o_req.valid      = 1'b1;
                        o_req.status     = sfp_pkg::ST_TAIL;
                        o_req.event_code = r_evt;
                        o_req.length     = r_len;
                        n_phase          = sfp_pkg::PH_HEAD1;
                    end else begin
                        n_phase = sfp_pkg::PH_TAIL2;
                    end
                end
                sfp_pkg::PH_TAIL2: begin
                    o_req.valid      = 1'b1;
                    o_req.event_code = r_evt;
                    o_req.length     = r_len;
                    n_phase          = sfp_pkg::PH_HEAD1;
                    if (i_rx_byte != r_tail_second) begin
                        o_req.status = sfp_pkg::ST_TAIL;
                    end else begin
                        o_req.status = sfp_pkg::ST_OK;
                        o_req.replay = (r_len != 8'd0);
                    end
                end
                default: begin
                    n_phase = sfp_pkg::PH_HEAD1;
                end
            endcase
        end
    end

endmodule

/* hw/rtl/sfp_out.sv */
// Result register and payload replay sequencer reading the payload store.
module sfp_out (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sfp_pkg::t_result_req       i_req,
    output logic                       o_in_free,
    output logic                       o_rd_en,
    output logic [sfp_pkg::RAM_AW-1:0] o_rd_addr,
    input  logic [7:0]                 i_rd_data,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output logic                       o_item_kind,
    output logic [2:0]                 o_frame_status,
    output logic [7:0]                 o_event_code,
    output logic [7:0]                 o_payload_length,
    output logic [7:0]                 o_payload_byte,
    output logic                       o_last_of_run
);

    sfp_pkg::t_ostate          r_state, n_state;
    logic                      r_valid, n_valid;
    logic [sfp_pkg::CNT_W-1:0] r_idx, n_idx;
    logic                      r_kind, n_kind;
    logic [2:0]                r_status, n_status;
    logic [7:0]                r_evt, n_evt;
    logic [7:0]                r_len, n_len;
    logic [7:0]                r_pb, n_pb;
    logic                      r_last, n_last;
    logic                      slot_free;
    logic [sfp_pkg::CNT_W-1:0] idx_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sfp_pkg::OS_IDLE;
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_status <= n_status;
        r_evt    <= n_evt;
        r_len    <= n_len;
        r_pb     <= n_pb;
        r_last   <= n_last;
    end

    assign slot_free = !r_valid || i_res_ready;
    assign idx_inc   = r_idx + sfp_pkg::CNT_W'(1);
    assign o_in_free = (r_state == sfp_pkg::OS_IDLE) && slot_free;
    assign o_rd_addr = r_idx[sfp_pkg::RAM_AW-1:0];

    always_comb begin
        n_state  = r_state;
        n_valid  = r_valid && !i_res_ready;
        n_idx    = r_idx;
        n_kind   = r_kind;
        n_status = r_status;
        n_evt    = r_evt;
        n_len    = r_len;
        n_pb     = r_pb;
        n_last   = r_last;
        o_rd_en  = 1'b0;
        case (r_state)
            sfp_pkg::OS_IDLE: begin
                if (i_req.valid) begin
                    n_valid  = 1'b1;
                    n_kind   = 1'b0;
                    n_status = i_req.status;
                    n_evt    = i_req.event_code;
                    n_len    = i_req.length;
                    n_pb     = 8'd0;
                    n_last   = !i_req.replay;
                    n_idx    = '0;
                    if (i_req.replay) begin
                        n_state = sfp_pkg::OS_READ;
                    end
                end
            end
            sfp_pkg::OS_READ: begin
                o_rd_en = 1'b1;
                n_state = sfp_pkg::OS_LOAD;
            end
            sfp_pkg::OS_LOAD: begin
                if (slot_free) begin
                    n_valid = 1'b1;
                    n_kind  = 1'b1;
                    n_pb    = i_rd_data;
                    n_last  = (8'(idx_inc) == r_len);
                    n_idx   = idx_inc;
                    n_state = (8'(idx_inc) == r_len) ? sfp_pkg::OS_IDLE : sfp_pkg::OS_READ;
                end
            end
            default: begin
                n_state = sfp_pkg::OS_IDLE;
            end
        endcase
    end

    assign o_res_valid      = r_valid;
    assign o_item_kind      = r_kind;
    assign o_frame_status   = r_status;
    assign o_event_code     = r_evt;
    assign o_payload_length = r_len;
    assign o_payload_byte   = r_pb;
    assign o_last_of_run    = r_last;

endmodule

/* hw/rtl/serial_frame_parser_checksum.sv */
// Serial frame parser with an 8-bit sum checksum and buffered payload replay.
// An input byte is taken only while the output stage is idle and its result slot is free;
// a status or header word appears at the output in the cycle after the byte that causes it.
// Each buffered payload word is then read from the payload store, whose read is registered
// (a read state, then a load state that waits for a free result slot); no input is taken until the replay ends.
// Synchronous active-low reset clears the parser, the configuration registers and the output state and valid flag.
module serial_frame_parser_checksum (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output logic       o_item_kind,
    output logic [2:0] o_frame_status,
    output logic [7:0] o_event_code,
    output logic [7:0] o_payload_length,
    output logic [7:0] o_payload_byte,
    output logic       o_last_of_run
);

    sfp_pkg::t_result_req       req;
    logic                       in_free;
    logic                       wr_en, rd_en;
    logic [sfp_pkg::RAM_AW-1:0] wr_addr, rd_addr;
    logic [7:0]                 wr_data, rd_data;

    assign o_cfg_ready = 1'b1;
    assign o_rx_ready  = in_free;

    sfp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (i_rx_valid && in_free),
        .i_rx_byte   (i_rx_byte),
        .o_req       (req),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    sfp_ram #(
        .WIDTH (8),
        .DEPTH (sfp_pkg::MAX_PAYLOAD)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    sfp_out u_out (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req            (req),
        .o_in_free        (in_free),
        .o_rd_en          (rd_en),
        .o_rd_addr        (rd_addr),
        .i_rd_data        (rd_data),
        .o_res_valid      (o_res_valid),
        .i_res_ready      (i_res_ready),
        .o_item_kind      (o_item_kind),
        .o_frame_status   (o_frame_status),
        .o_event_code     (o_event_code),
        .o_payload_length (o_payload_length),
        .o_payload_byte   (o_payload_byte),
        .o_last_of_run    (o_last_of_run)
    );

endmodule
